### hdl/fbsm_pkg.sv
// Shared types, widths and codes of the frame buffer slot manager.
`timescale 1ns / 1ps
`default_nettype none

package fbsm_pkg;

    // Pool and ring limits
    localparam int MAX_FRAMES       = 8;
    localparam int MAX_HALF_BUFFERS = 16;

    // Field and state widths
    localparam int SLOT_W     = 3;
    localparam int HALF_W     = 4;
    localparam int RING_W     = 5;
    localparam int POOL_W     = 4;
    localparam int COUNT_W    = 4;
    localparam int MODE_W     = 2;
    localparam int NUMF_W     = 4;
    localparam int FSIZE_W    = 21;
    localparam int HBB_W      = 17;
    localparam int HBC_W      = 5;
    localparam int OSTEP_W    = 17;
    localparam int OFS_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BUFFER_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BUFFER_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_STEP     = 3'd4;

    // Event codes
    localparam logic [MODE_W-1:0] MODE_VSYNC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HALF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TAKE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_GIVE  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] give_slot;
    } fbsm_in_t;

    typedef struct packed {
        logic              copy_valid;
        logic [SLOT_W-1:0] copy_slot;
        logic [OFS_W-1:0]  copy_dest_offset;
        logic [OFS_W-1:0]  copy_src_offset;
        logic              taken_valid;
        logic [SLOT_W-1:0] taken_slot;
        logic              capturing;
        logic              overflow;
        logic              discarded;
        logic              dropped_oldest;
        logic              no_free_slot;
    } fbsm_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_COMMIT
    } fbsm_state_t;

    typedef struct packed {
        logic load;
        logic reduce_step;
        logic commit;
    } fbsm_cmd_t;

    typedef struct packed {
        logic reduce_done;
    } fbsm_status_t;

endpackage

`default_nettype wire

### hdl/frame_buffer_slot_manager_core.sv
// Top level of the frame buffer slot manager.
//
// Usage: each input item carries an event (vsync, DMA half buffer done, take
// a ready frame, give a slot back) and produces exactly one result item with
// the copy command, the handed-out slot and the status flags.
// Channels: s_valid/s_ready/s_data take items, m_valid/m_ready/m_data deliver
// results, cfg_valid/cfg_ready/cfg_index/cfg_data write the five registers
// (cfg_ready is always high). Write configuration only while idle.
// Timing: an item is latched on acceptance, then the DMA ring index is
// reduced modulo the ring size by one subtraction a cycle, then the commit
// state updates the state and loads the result register. The number of
// subtractions is 0 to 15; it is 0 unless the ring size was lowered to or
// below the stored index.
// One item is in work at a time; the next is accepted once the result has
// been loaded, so a waiting result does not block acceptance.
// Stall: when m_ready is low the result is held and the next item waits in
// its commit cycle.
// Reset: aresetn low (synchronous) restores register defaults, frees every
// slot, empties the ready FIFO and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module frame_buffer_slot_manager_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire fbsm_pkg::fbsm_in_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output fbsm_pkg::fbsm_out_t                    m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fbsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fbsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fbsm_pkg::*;

    fbsm_cmd_t    cmd;
    fbsm_status_t status;

    // Registers accept a write in every cycle
    assign cfg_ready = 1'b1;

    fbsm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fbsm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

### hdl/fbsm_ctrl.sv
// Controller state machine of the frame buffer slot manager.
`timescale 1ns / 1ps
`default_nettype none

module fbsm_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire fbsm_pkg::fbsm_status_t status,
    output fbsm_pkg::fbsm_cmd_t        cmd
);
    import fbsm_pkg::*;

    fbsm_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    // Output register can take a new result when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (status.reduce_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs
    always_comb begin
        s_ready         = 1'b0;
        cmd.load        = 1'b0;
        cmd.reduce_step = 1'b0;
        cmd.commit      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_REDUCE: begin
                cmd.reduce_step = !status.reduce_done;
            end
            ST_COMMIT: begin
                cmd.commit = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/fbsm_datapath.sv
// Datapath of the frame buffer slot manager: registers, slot pool, ready FIFO.
`timescale 1ns / 1ps
`default_nettype none

module fbsm_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire fbsm_pkg::fbsm_cmd_t               cmd,
    output fbsm_pkg::fbsm_status_t                 status,
    input  wire fbsm_pkg::fbsm_in_t                s_data,
    input  wire logic                              cfg_valid,
    input  wire logic [fbsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fbsm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fbsm_pkg::fbsm_out_t                    m_data
);
    import fbsm_pkg::*;

    // Configuration
    logic [NUMF_W-1:0]  num_frames_reg;
    logic [FSIZE_W-1:0] frame_size_reg;
    logic [HBB_W-1:0]   hbb_reg;
    logic [HBC_W-1:0]   hbc_reg;
    logic [OSTEP_W-1:0] ostep_reg;

    // Item and ring index reduction
    fbsm_in_t           in_reg;
    logic [HALF_W-1:0]  hi_work_reg;
    logic [RING_W-1:0]  hi_sub;

    // Block state
    logic                  capturing_reg, capturing_next;
    logic [SLOT_W-1:0]     cur_slot_reg, cur_slot_next;
    logic [FSIZE_W-1:0]    fill_reg, fill_next;
    logic [HALF_W-1:0]     half_idx_reg, half_idx_next;
    logic [MAX_FRAMES-1:0] slot_free_reg, slot_free_next;
    logic [SLOT_W-1:0]     queue_reg [MAX_FRAMES];
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    // Result register
    fbsm_out_t          out_reg, out_next;

    // Derived values
    logic [POOL_W-1:0]     pool_n;
    logic [RING_W-1:0]     ring_n;
    logic [COUNT_W-1:0]    fifo_cap;
    logic [MAX_FRAMES-1:0] pool_mask;
    logic [SLOT_W-1:0]     head_slot;
    logic [SLOT_W-1:0]     q_waddr;
    logic                  q_we;
    logic                  found;
    logic [SLOT_W-1:0]     pick;
    logic [FSIZE_W:0]      ovf_sum;
    logic [FSIZE_W:0]      fill_sum;
    logic [HALF_W+HBB_W-1:0] src_prod;
    logic [RING_W-1:0]     hi_inc;

    // Clamp slot count and ring count into range
    always_comb begin
        if (num_frames_reg == '0) begin
            pool_n = POOL_W'(1);
        end else if (num_frames_reg > NUMF_W'(MAX_FRAMES)) begin
            pool_n = POOL_W'(MAX_FRAMES);
        end else begin
            pool_n = num_frames_reg;
        end
        if (hbc_reg == '0) begin
            ring_n = RING_W'(1);
        end else if (hbc_reg > HBC_W'(MAX_HALF_BUFFERS)) begin
            ring_n = RING_W'(MAX_HALF_BUFFERS);
        end else begin
            ring_n = hbc_reg;
        end
        fifo_cap = (pool_n > POOL_W'(1)) ? COUNT_W'(pool_n - POOL_W'(1)) : COUNT_W'(1);
        for (int i = 0; i < MAX_FRAMES; i++) begin
            pool_mask[i] = (POOL_W'(i) < pool_n);
        end
    end

    // Reduce the ring index one subtraction a cycle
    assign hi_sub             = {1'b0, hi_work_reg} - ring_n;
    assign status.reduce_done = ({1'b0, hi_work_reg} < ring_n);

    assign head_slot = queue_reg[head_reg];
    assign q_waddr   = SLOT_W'(COUNT_W'(head_reg) + count_reg);
    assign ovf_sum   = {1'b0, fill_reg} + (FSIZE_W + 1)'(ostep_reg);
    assign fill_sum  = {1'b0, fill_reg} + (FSIZE_W + 1)'(hbb_reg);
    assign src_prod  = (HALF_W + HBB_W)'(hi_work_reg) * (HALF_W + HBB_W)'(hbb_reg);
    assign hi_inc    = {1'b0, hi_work_reg} + RING_W'(1);

    // Work out the effect of one event
    always_comb begin
        capturing_next = capturing_reg;
        cur_slot_next  = cur_slot_reg;
        fill_next      = fill_reg;
        half_idx_next  = half_idx_reg;
        slot_free_next = slot_free_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        q_we           = 1'b0;
        found          = 1'b0;
        pick           = '0;
        out_next       = '0;
        case (in_reg.mode)
            MODE_VSYNC: begin
                // Close the frame being filled
                if (capturing_reg) begin
                    if ({1'b0, fill_reg} != {1'b0, frame_size_reg}) begin
                        slot_free_next[cur_slot_reg] = 1'b1;
                        out_next.discarded           = 1'b1;
                    end else begin
                        slot_free_next[cur_slot_reg] = 1'b0;
                        q_we                         = 1'b1;
                        if (count_reg >= fifo_cap) begin
                            head_next               = head_reg + SLOT_W'(1);
                            out_next.dropped_oldest = 1'b1;
                            if (pool_mask[head_slot]) begin
                                slot_free_next[head_slot] = 1'b1;
                            end
                        end else begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                    end
                end
                // Pick the next slot: current if free, else lowest free
                for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
                    if (slot_free_next[i] && pool_mask[i]) begin
                        found = 1'b1;
                        pick  = SLOT_W'(i);
                    end
                end
                if (pool_mask[cur_slot_reg] && slot_free_next[cur_slot_reg]) begin
                    capturing_next = 1'b1;
                    fill_next      = '0;
                end else if (found) begin
                    cur_slot_next  = pick;
                    capturing_next = 1'b1;
                    fill_next      = '0;
                end else begin
                    capturing_next        = 1'b0;
                    out_next.no_free_slot = 1'b1;
                end
                half_idx_next = '0;
            end
            MODE_HALF: begin
                if (capturing_reg) begin
                    if ({1'b0, frame_size_reg} < ovf_sum) begin
                        out_next.overflow = 1'b1;
                    end else begin
                        out_next.copy_valid       = 1'b1;
                        out_next.copy_slot        = cur_slot_reg;
                        out_next.copy_dest_offset = fill_reg[OFS_W-1:0];
                        out_next.copy_src_offset  = src_prod[OFS_W-1:0];
                        fill_next = fill_sum[FSIZE_W] ? '1 : fill_sum[FSIZE_W-1:0];
                        half_idx_next = (hi_inc == ring_n) ? '0 : hi_inc[HALF_W-1:0];
                    end
                end
            end
            MODE_TAKE: begin
                if (count_reg != '0) begin
                    out_next.taken_valid = 1'b1;
                    out_next.taken_slot  = head_slot;
                    head_next            = head_reg + SLOT_W'(1);
                    count_next           = count_reg - COUNT_W'(1);
                end
            end
            MODE_GIVE: begin
                if (pool_mask[in_reg.give_slot]) begin
                    slot_free_next[in_reg.give_slot] = 1'b1;
                end
            end
            default: begin
                out_next = '0;
            end
        endcase
        out_next.capturing = capturing_next;
    end

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_frames_reg <= NUMF_W'(2);
            frame_size_reg <= FSIZE_W'(3840);
            hbb_reg        <= HBB_W'(1024);
            hbc_reg        <= HBC_W'(2);
            ostep_reg      <= OSTEP_W'(1024);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_NUM_FRAMES:        num_frames_reg <= cfg_data[NUMF_W-1:0];
                CFG_FRAME_SIZE:        frame_size_reg <= cfg_data[FSIZE_W-1:0];
                CFG_HALF_BUFFER_BYTES: hbb_reg        <= cfg_data[HBB_W-1:0];
                CFG_HALF_BUFFER_COUNT: hbc_reg        <= cfg_data[HBC_W-1:0];
                CFG_OVERFLOW_STEP:     ostep_reg      <= cfg_data[OSTEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Latch the item and step the ring index reduction
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg      <= s_data;
            hi_work_reg <= half_idx_reg;
        end else if (cmd.reduce_step) begin
            hi_work_reg <= hi_sub[HALF_W-1:0];
        end
    end

    // Advance block state on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg <= 1'b0;
            cur_slot_reg  <= '0;
            fill_reg      <= '0;
            half_idx_reg  <= '0;
            slot_free_reg <= '1;
            head_reg      <= '0;
            count_reg     <= '0;
        end else if (cmd.commit) begin
            capturing_reg <= capturing_next;
            cur_slot_reg  <= cur_slot_next;
            fill_reg      <= fill_next;
            half_idx_reg  <= half_idx_next;
            slot_free_reg <= slot_free_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
        end
    end

    // Append to the ready FIFO and load the result
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_reg <= out_next;
            if (q_we) begin
                queue_reg[q_waddr] <= cur_slot_reg;
            end
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire
